// ===== rtl/core/dbcs_pkg.sv =====
// shared types and constants for the direct buffer channel store
package dbcs_pkg;

    localparam int MODE_W       = 3;
    localparam int CHAN_W       = 7;
    localparam int BNUM_W       = 4;
    localparam int BYTE_W       = 8;
    localparam int BUFFER_BYTES = 256;

    localparam logic [MODE_W-1:0] MODE_OPEN_ANY = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN_NUM = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLOSE    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SET_PTR  = 3'd5;

    typedef struct packed {
        logic clear;
        logic execute;
        logic finish;
    } dbcs_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } dbcs_stat_t;

endpackage

// ===== rtl/core/dbcs_ctrl.sv =====
// controller state machine: store clearing, command execution and result hand-off
module dbcs_ctrl
    import dbcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dbcs_stat_t stat,
    output dbcs_cmd_t  cmd
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.clear   = 1'b0;
        cmd.execute = 1'b0;
        cmd.finish  = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.execute = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/core/dbcs_datapath.sv =====
// buffer table, data store and result register
module dbcs_datapath
    import dbcs_pkg::*;
#(
    parameter int NUM_BUFFERS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dbcs_cmd_t         cmd,
    output dbcs_stat_t        stat,
    input  logic [MODE_W-1:0] mode,
    input  logic [CHAN_W-1:0] channel,
    input  logic [BNUM_W-1:0] buffer_number,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_status,
    output logic [BYTE_W-1:0] out_read_data,
    output logic              out_at_end
);

    localparam int BIDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int DEPTH  = NUM_BUFFERS * BUFFER_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [NUM_BUFFERS-1:0] owner_valid_reg;
    logic [NUM_BUFFERS-1:0] loaded_reg;
    logic [CHAN_W-1:0]      owner_ch_reg [NUM_BUFFERS];
    logic [BYTE_W-1:0]      rd_ptr_reg   [NUM_BUFFERS];
    logic [BYTE_W-1:0]      wr_ptr_reg   [NUM_BUFFERS];
    logic [BYTE_W-1:0]      last_reg     [NUM_BUFFERS];

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] mem_q_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic              pend_status_reg;
    logic              pend_end_reg;
    logic              pend_mem_reg;
    logic [BYTE_W-1:0] pend_data_reg;

    logic              out_valid_reg;
    logic              out_status_reg;
    logic              out_end_reg;
    logic [BYTE_W-1:0] out_data_reg;

    logic [NUM_BUFFERS-1:0] match;
    logic                   own_found;
    logic [BIDX_W-1:0]      own_idx;
    logic                   free_found;
    logic [BIDX_W-1:0]      free_idx;
    logic                   bn_ok;
    logic [BIDX_W-1:0]      bn_idx;
    logic [BYTE_W-1:0]      rp;
    logic [BYTE_W-1:0]      wp;
    logic [BYTE_W-1:0]      lv;
    logic                   ld;
    logic                   read_last;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_addr;
    logic [BYTE_W-1:0]      mem_wdata;
    logic                   res_status;
    logic                   res_end;
    logic                   res_mem;
    logic [BYTE_W-1:0]      res_data;

    // lowest owned and lowest free buffer
    always_comb begin
        own_found  = 1'b0;
        own_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
            match[i] = owner_valid_reg[i] && (owner_ch_reg[i] == channel);
            if (match[i]) begin
                own_found = 1'b1;
                own_idx   = BIDX_W'(i);
            end
            if (!owner_valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = BIDX_W'(i);
            end
        end
    end

    assign bn_idx    = BIDX_W'(buffer_number);
    assign bn_ok     = ((BNUM_W + 1)'(buffer_number) < (BNUM_W + 1)'(NUM_BUFFERS))
                       && !owner_valid_reg[bn_idx];
    assign rp        = rd_ptr_reg[own_idx];
    assign wp        = wr_ptr_reg[own_idx];
    assign lv        = last_reg[own_idx];
    assign ld        = loaded_reg[own_idx];
    assign read_last = (lv != '0) && (rp == lv);

    always_comb begin
        res_status = 1'b0;
        res_end    = 1'b0;
        res_mem    = 1'b0;
        res_data   = '0;
        case (mode)
            MODE_OPEN_ANY: res_status = !free_found;
            MODE_OPEN_NUM: res_status = !bn_ok;
            MODE_READ: begin
                res_status = !own_found;
                res_end    = !own_found || !ld || read_last;
                res_mem    = own_found && ld;
                if (own_found && !ld) begin
                    res_data = BYTE_W'(own_idx);
                end
            end
            MODE_WRITE:   res_status = !own_found;
            MODE_CLOSE:   res_status = !own_found;
            MODE_SET_PTR: res_status = !own_found;
            default: ;
        endcase
    end

    // data store port
    assign mem_we    = cmd.clear || (cmd.execute && (mode == MODE_WRITE) && own_found);
    assign mem_re    = cmd.execute && (mode == MODE_READ) && own_found && ld;
    assign mem_wdata = cmd.clear ? '0 : data_byte;
    assign mem_addr  = cmd.clear ? clr_cnt_reg
                     : ADDR_W'({own_idx, (mode == MODE_WRITE) ? wp : rp});

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign stat.clear_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign stat.out_busy   = out_valid_reg && !out_ready;

    // buffer table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_valid_reg <= '0;
            loaded_reg      <= '0;
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                owner_ch_reg[i] <= '0;
                rd_ptr_reg[i]   <= '0;
                wr_ptr_reg[i]   <= '0;
                last_reg[i]     <= '0;
            end
        end else if (cmd.execute) begin
            case (mode)
                MODE_OPEN_ANY: begin
                    if (free_found) begin
                        owner_valid_reg[free_idx] <= 1'b1;
                        owner_ch_reg[free_idx]    <= channel;
                        rd_ptr_reg[free_idx]      <= BYTE_W'(1);
                        wr_ptr_reg[free_idx]      <= BYTE_W'(1);
                        loaded_reg[free_idx]      <= 1'b0;
                    end
                end
                MODE_OPEN_NUM: begin
                    if (bn_ok) begin
                        owner_valid_reg[bn_idx] <= 1'b1;
                        owner_ch_reg[bn_idx]    <= channel;
                        rd_ptr_reg[bn_idx]      <= BYTE_W'(1);
                        wr_ptr_reg[bn_idx]      <= BYTE_W'(1);
                        loaded_reg[bn_idx]      <= 1'b0;
                    end
                end
                MODE_READ: begin
                    if (own_found && ld) begin
                        if (read_last) begin
                            rd_ptr_reg[own_idx] <= '0;
                            wr_ptr_reg[own_idx] <= BYTE_W'(1);
                        end else begin
                            rd_ptr_reg[own_idx] <= rp + 1'b1;
                            wr_ptr_reg[own_idx] <= rp;
                        end
                    end
                end
                MODE_WRITE: begin
                    if (own_found) begin
                        rd_ptr_reg[own_idx] <= wp + 1'b1;
                        wr_ptr_reg[own_idx] <= wp + 1'b1;
                        loaded_reg[own_idx] <= 1'b1;
                        last_reg[own_idx]   <= (wp == '1) ? '0 : wp;
                    end
                end
                MODE_CLOSE: begin
                    owner_valid_reg <= owner_valid_reg & ~match;
                end
                MODE_SET_PTR: begin
                    if (own_found) begin
                        rd_ptr_reg[own_idx] <= data_byte;
                        wr_ptr_reg[own_idx] <= data_byte;
                    end
                end
                default: ;
            endcase
        end
    end

    // result held until the store read returns
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            pend_status_reg <= res_status;
            pend_end_reg    <= res_end;
            pend_mem_reg    <= res_mem;
            pend_data_reg   <= res_data;
        end
        if (cmd.finish) begin
            out_status_reg <= pend_status_reg;
            out_end_reg    <= pend_end_reg;
            out_data_reg   <= pend_mem_reg ? mem_q_reg : pend_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_read_data = out_data_reg;
    assign out_at_end    = out_end_reg;

endmodule

// ===== rtl/core/direct_buffer_channel_store.sv =====
// top level of the direct buffer channel store
//
// channel   direction  content
// s_        in         tuser: mode; tdata: channel, buffer_number, data_byte
// m_        out        tdata: status, read_data; tlast: at_end
//
// a word is taken, then its result is formed in the finishing step once the result
// port is free, from the registered store read; no word is taken until then
// after reset the data store is zeroed, one byte a cycle, over all NUM_BUFFERS * 256
// bytes; no word is taken during that pass
// a stalled result holds the block in its finishing step; a new word is taken
// while the previous result still waits
module direct_buffer_channel_store
    import dbcs_pkg::*;
#(
    parameter int NUM_BUFFERS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // channel[6:0], buffer_number[10:7], data_byte[18:11]
    input  logic [MODE_W-1:0] s_tuser,   // mode[2:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // status[0], read_data[8:1]
    output logic              m_tlast
);

    dbcs_cmd_t         cmd;
    dbcs_stat_t        stat;
    logic              out_status;
    logic [BYTE_W-1:0] out_read_data;

    dbcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dbcs_datapath #(
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (s_tuser),
        .channel       (s_tdata[6:0]),
        .buffer_number (s_tdata[10:7]),
        .data_byte     (s_tdata[18:11]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (out_status),
        .out_read_data (out_read_data),
        .out_at_end    (m_tlast)
    );

    assign m_tdata = {7'd0, out_read_data, out_status};

    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && !cmd.clear))
        else $error("word taken before previous one finished");

    a_finish_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid)
        else $error("finished word produced no result");

    a_no_take_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clear && s_tready))
        else $error("word taken during store clearing");

    a_finish_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !cmd.finish)
        else $error("result overwritten while stalled");

endmodule
